// ----- hw/rtl/tcs_pkg.sv -----
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types, codes and the character table for the text character statistics
// block.
// ----------------------------------------------------------------------------
package tcs_pkg;

    typedef enum logic [1:0] {
        FUNC_DATA  = 2'd0,
        FUNC_EOL   = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_CLEAR = 2'd3
    } tcs_func_t;

    typedef struct packed {
        tcs_func_t   func;
        logic [7:0]  data_byte;
        logic [6:0]  read_index;
    } tcs_in_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic        index_valid;
        logic [4:0]  line_length_now;
    } tcs_out_t;

    // read, write and clear controls of the counter ram
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } tcs_mem_ctl_t;

    localparam int NUM_CLASSES  = 5;
    localparam int NUM_CHARS    = 89;
    localparam int FIRST_SYMBOL = 62;

    localparam logic [2:0] CLS_LOWER  = 3'd0;
    localparam logic [2:0] CLS_UPPER  = 3'd1;
    localparam logic [2:0] CLS_DIGIT  = 3'd2;
    localparam logic [2:0] CLS_SYMBOL = 3'd3;
    localparam logic [2:0] CLS_OTHER  = 3'd4;

    localparam logic [7:0] CHAR_TABLE [NUM_CHARS] = '{
        // a-z
        8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A,
        8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74,
        8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A,
        // A-Z
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
        8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
        8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
        // 1-9 then 0
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
        // symbols
        8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
        8'h2D, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h3A, 8'h3B, 8'h22, 8'h27, 8'h3C,
        8'h3E, 8'h2E, 8'h2F, 8'h3F, 8'h7E, 8'h60, 8'h20
    };

    typedef struct packed {
        logic       hit;
        logic [6:0] pos;
    } tcs_char_hit_t;

    function automatic tcs_char_hit_t char_lookup(input logic [7:0] b);
        tcs_char_hit_t r;
        r.hit = 1'b0;
        r.pos = '0;
        for (int i = 0; i < NUM_CHARS; i++) begin
            if (CHAR_TABLE[i] == b) begin
                r.hit = 1'b1;
                r.pos = 7'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [2:0] char_class(input logic [7:0] b, input tcs_char_hit_t ch);
        logic [2:0] c;
        if (b >= 8'h61 && b <= 8'h7A) begin
            c = CLS_LOWER;
        end else if (b >= 8'h41 && b <= 8'h5A) begin
            c = CLS_UPPER;
        end else if (b >= 8'h30 && b <= 8'h39) begin
            c = CLS_DIGIT;
        end else if (ch.hit && ch.pos >= 7'(FIRST_SYMBOL)) begin
            c = CLS_SYMBOL;
        end else begin
            c = CLS_OTHER;
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/tcs_counter_store.sv -----
// ----------------------------------------------------------------------------
// tcs_counter_store
// Counter ram with one read and one write port, per-entry valid bits for
// instant clear, and forwarding of a write that lands on the same edge as a
// read of the same entry.
// ----------------------------------------------------------------------------
module tcs_counter_store #(
    parameter int DEPTH = 120,
    parameter int AW    = 7,
    parameter int CW    = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tcs_pkg::tcs_mem_ctl_t ctl,
    input  logic [AW-1:0]         rd_addr,
    input  logic [AW-1:0]         wr_addr,
    input  logic [CW-1:0]         wr_data,
    output logic [CW-1:0]         rd_value
);

    logic [CW-1:0]    mem [DEPTH];
    logic [CW-1:0]    rd_data_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             rd_vld_reg;
    logic             fwd_hit_reg;
    logic [CW-1:0]    fwd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end else begin
            if (ctl.clr) begin
                vld_reg <= '0;
            end else if (ctl.wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en) begin
                // a clear on the same edge empties the entry being read
                rd_vld_reg  <= vld_reg[rd_addr] && !ctl.clr;
                fwd_hit_reg <= ctl.wr_en && (wr_addr == rd_addr);
            end
        end
    end

    always_comb begin
        if (fwd_hit_reg) begin
            rd_value = fwd_data_reg;
        end else if (rd_vld_reg) begin
            rd_value = rd_data_reg;
        end else begin
            rd_value = '0;
        end
    end

endmodule

// ----- hw/rtl/text_character_statistics.sv -----
// ----------------------------------------------------------------------------
// text_character_statistics
// Line-length histogram, byte-class, per-character and total counters over a
// text byte stream, with counter read-back and clear.
// ----------------------------------------------------------------------------
// path: an accepted item passes the ram stage, then the result register
// throughput: one item per cycle unless the output stalls; ram read at accept
//   and write-back on leaving the ram stage; same-entry overlap is forwarded
// reset: control, line length, class and total counters clear at once; ram
//   entries read as zero through valid bits until written, no sweep
module text_character_statistics #(
    parameter int LENGTH_CAP  = 30,
    parameter int COUNT_WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tcs_pkg::tcs_in_t s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output tcs_pkg::tcs_out_t m_item
);

    localparam int NUM_BINS     = LENGTH_CAP + 1;
    localparam int IDX_CLASS    = NUM_BINS;
    localparam int IDX_CHAR     = IDX_CLASS + tcs_pkg::NUM_CLASSES;
    localparam int IDX_LINES    = IDX_CHAR + tcs_pkg::NUM_CHARS;
    localparam int IDX_BYTES    = IDX_LINES + 1;
    localparam int NUM_COUNTERS = IDX_BYTES + 1;
    localparam int MEM_DEPTH    = NUM_BINS + tcs_pkg::NUM_CHARS;
    localparam int AW           = $clog2(MEM_DEPTH);
    localparam int IW           = AW + 1;
    localparam int LW           = $clog2(LENGTH_CAP + 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // handshake
    logic accept;
    logic out_free;
    logic p1_adv;
    logic p1_valid_reg;
    logic m_valid_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign p1_adv   = p1_valid_reg && out_free;
    assign s_ready  = !p1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    // accept stage decode
    tcs_pkg::tcs_char_hit_t ch;
    logic [2:0]             cls;
    logic [IW-1:0]          idx;
    logic                   idx_valid;
    logic                   in_bins;
    logic                   in_chars;
    logic [AW-1:0]          idx_addr;
    logic [AW-1:0]          mem_addr;
    logic [COUNT_WIDTH-1:0] reg_val;

    logic [LW-1:0]          len_reg;
    logic [LW-1:0]          len_next;
    logic [COUNT_WIDTH-1:0] class_cnt_reg [tcs_pkg::NUM_CLASSES];
    logic [COUNT_WIDTH-1:0] lines_cnt_reg;
    logic [COUNT_WIDTH-1:0] bytes_cnt_reg;

    assign ch  = tcs_pkg::char_lookup(s_item.data_byte);
    assign cls = tcs_pkg::char_class(s_item.data_byte, ch);
    assign idx = IW'(s_item.read_index);

    assign idx_valid = idx < IW'(NUM_COUNTERS);
    assign in_bins   = idx < IW'(NUM_BINS);
    assign in_chars  = (idx >= IW'(IDX_CHAR)) && (idx < IW'(IDX_LINES));
    assign idx_addr  = in_bins ? AW'(idx) : AW'(idx - IW'(tcs_pkg::NUM_CLASSES));

    always_comb begin
        reg_val = '0;
        for (int i = 0; i < tcs_pkg::NUM_CLASSES; i++) begin
            if (idx == IW'(IDX_CLASS + i)) begin
                reg_val = class_cnt_reg[i];
            end
        end
        if (idx == IW'(IDX_LINES)) begin
            reg_val = lines_cnt_reg;
        end
        if (idx == IW'(IDX_BYTES)) begin
            reg_val = bytes_cnt_reg;
        end
    end

    always_comb begin
        unique case (s_item.func)
            tcs_pkg::FUNC_DATA:  mem_addr = AW'(NUM_BINS) + AW'(ch.pos);
            tcs_pkg::FUNC_EOL:   mem_addr = AW'(len_reg);
            tcs_pkg::FUNC_READ:  mem_addr = idx_addr;
            tcs_pkg::FUNC_CLEAR: mem_addr = '0;
            default:             mem_addr = '0;
        endcase
    end

    always_comb begin
        unique case (s_item.func)
            tcs_pkg::FUNC_DATA: begin
                len_next = (len_reg < LW'(LENGTH_CAP)) ? len_reg + 1'b1 : len_reg;
            end
            tcs_pkg::FUNC_READ: len_next = len_reg;
            default:            len_next = '0;
        endcase
    end

    // line length, class and total counters update at accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            lines_cnt_reg <= '0;
            bytes_cnt_reg <= '0;
            for (int i = 0; i < tcs_pkg::NUM_CLASSES; i++) begin
                class_cnt_reg[i] <= '0;
            end
        end else if (accept) begin
            len_reg <= len_next;
            unique case (s_item.func)
                tcs_pkg::FUNC_DATA: begin
                    bytes_cnt_reg <= sat_inc(bytes_cnt_reg);
                    for (int i = 0; i < tcs_pkg::NUM_CLASSES; i++) begin
                        if (cls == 3'(i)) begin
                            class_cnt_reg[i] <= sat_inc(class_cnt_reg[i]);
                        end
                    end
                end
                tcs_pkg::FUNC_EOL: begin
                    lines_cnt_reg <= sat_inc(lines_cnt_reg);
                end
                tcs_pkg::FUNC_CLEAR: begin
                    lines_cnt_reg <= '0;
                    bytes_cnt_reg <= '0;
                    for (int i = 0; i < tcs_pkg::NUM_CLASSES; i++) begin
                        class_cnt_reg[i] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ram stage
    tcs_pkg::tcs_func_t     p1_func_reg;
    logic                   p1_wr_reg;
    logic                   p1_rd_mem_reg;
    logic [AW-1:0]          p1_addr_reg;
    logic [COUNT_WIDTH-1:0] p1_reg_val_reg;
    logic                   p1_idx_valid_reg;
    logic [LW-1:0]          p1_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_adv) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_func_reg      <= s_item.func;
            p1_wr_reg        <= (s_item.func == tcs_pkg::FUNC_DATA && ch.hit)
                                || s_item.func == tcs_pkg::FUNC_EOL;
            p1_rd_mem_reg    <= in_bins || in_chars;
            p1_addr_reg      <= mem_addr;
            p1_reg_val_reg   <= reg_val;
            p1_idx_valid_reg <= idx_valid;
            p1_len_reg       <= len_next;
        end
    end

    tcs_pkg::tcs_mem_ctl_t  mem_ctl;
    logic [COUNT_WIDTH-1:0] cur_val;
    logic [COUNT_WIDTH-1:0] wr_val;

    assign mem_ctl.rd_en = accept;
    assign mem_ctl.wr_en = p1_adv && p1_wr_reg;
    assign mem_ctl.clr   = p1_adv && (p1_func_reg == tcs_pkg::FUNC_CLEAR);
    assign wr_val        = sat_inc(cur_val);

    tcs_counter_store #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW),
        .CW    (COUNT_WIDTH)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (mem_ctl),
        .rd_addr  (mem_addr),
        .wr_addr  (p1_addr_reg),
        .wr_data  (wr_val),
        .rd_value (cur_val)
    );

    // result register
    tcs_pkg::tcs_out_t result;
    tcs_pkg::tcs_out_t m_item_reg;

    always_comb begin
        result.read_value      = '0;
        if (p1_func_reg == tcs_pkg::FUNC_READ) begin
            result.read_value = p1_rd_mem_reg ? 32'(cur_val) : 32'(p1_reg_val_reg);
        end
        result.index_valid     = p1_idx_valid_reg;
        result.line_length_now = 5'(p1_len_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            m_item_reg <= result;
        end
    end

    assign m_item = m_item_reg;

    // checks
    a_len_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(LENGTH_CAP))
        else $error("line length above cap");

    a_clear_len: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_item.func == tcs_pkg::FUNC_CLEAR |=> len_reg == '0)
        else $error("clear did not reset line length");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_item_reg.index_valid |-> m_item_reg.read_value == '0)
        else $error("nonzero value for invalid index");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && !out_free |=> p1_valid_reg && $stable(p1_addr_reg))
        else $error("ram stage item lost while stalled");

endmodule

// ----- sim/text_character_statistics_test.sv -----
// ----------------------------------------------------------------------------
// text_character_statistics_test
// Self-checking bench for the text statistics block: a scoreboard keeps its own
// copy of every counter, predicts each readout from the accepted items and
// compares it field by field, while bursty input and a stalling output shake
// the pipeline and its forwarding path.
// ----------------------------------------------------------------------------
module text_character_statistics_test;

    localparam int ITEM_COUNT  = 1550;
    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 8;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_MOSTLY,
        RX_PERIODIC
    } rx_mode_t;

    class stats_board;
        localparam int BIN_LAST     = 30;
        localparam int IDX_CLASS    = 31;
        localparam int IDX_CHAR     = 36;
        localparam int IDX_LINES    = 125;
        localparam int IDX_BYTES    = 126;
        localparam int NUM_COUNTERS = 127;
        localparam int SYMBOL_POS   = 62;

        // counted characters in counter order, the backtick written as octal
        string glyphs =
            "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890!@#$%^&*()-{}[]:;\"'<>./?~\140 ";
        logic [31:0]       tally [NUM_COUNTERS];
        logic [4:0]        line_len;
        tcs_pkg::tcs_out_t expected_readouts [$];
        int                errors;

        function new();
            errors = 0;
            clear_stats();
        endfunction

        function void clear_stats();
            foreach (tally[i]) tally[i] = '0;
            line_len = '0;
        endfunction

        function void bump(int i);
            if (tally[i] != '1) tally[i] = tally[i] + 1'b1;
        endfunction

        function int glyph_pos(logic [7:0] b);
            for (int i = 0; i < glyphs.len(); i++) begin
                if (glyphs[i] == b) return i;
            end
            return -1;
        endfunction

        function void count_byte(logic [7:0] b);
            int pos;
            int cls;
            pos = glyph_pos(b);
            if (b >= 8'h61 && b <= 8'h7A) begin
                cls = tcs_pkg::CLS_LOWER;
            end else if (b >= 8'h41 && b <= 8'h5A) begin
                cls = tcs_pkg::CLS_UPPER;
            end else if (b >= 8'h30 && b <= 8'h39) begin
                cls = tcs_pkg::CLS_DIGIT;
            end else if (pos >= SYMBOL_POS) begin
                cls = tcs_pkg::CLS_SYMBOL;
            end else begin
                cls = tcs_pkg::CLS_OTHER;
            end
            bump(IDX_CLASS + cls);
            if (pos >= 0) bump(IDX_CHAR + pos);
            bump(IDX_BYTES);
            if (line_len < BIN_LAST) line_len = line_len + 1'b1;
        endfunction

        function int pending();
            return expected_readouts.size();
        endfunction

        task report(string what);
            errors++;
            $display("mismatch %0d at %0t: %s", errors, $time, what);
        endtask

        // expected readout of one accepted item, state updated after the read
        function void take_item(tcs_pkg::tcs_in_t it);
            tcs_pkg::tcs_out_t r;
            r.index_valid = (it.read_index < NUM_COUNTERS);
            r.read_value  = (it.func == tcs_pkg::FUNC_READ && r.index_valid)
                            ? tally[it.read_index] : '0;
            case (it.func)
                tcs_pkg::FUNC_DATA: count_byte(it.data_byte);
                tcs_pkg::FUNC_EOL: begin
                    bump(line_len);
                    bump(IDX_LINES);
                    line_len = '0;
                end
                tcs_pkg::FUNC_CLEAR: clear_stats();
                default: ;
            endcase
            r.line_length_now = line_len;
            expected_readouts.push_back(r);
        endfunction

        task check_readout(tcs_pkg::tcs_out_t got);
            tcs_pkg::tcs_out_t want;
            if (expected_readouts.size() == 0) begin
                report($sformatf("result %h with nothing expected", got));
                return;
            end
            want = expected_readouts.pop_front();
            if (got.read_value !== want.read_value)
                report($sformatf("read_value %h, expected %h", got.read_value, want.read_value));
            if (got.index_valid !== want.index_valid)
                report($sformatf("index_valid %b, expected %b", got.index_valid, want.index_valid));
            if (got.line_length_now !== want.line_length_now)
                report($sformatf("line_length_now %0d, expected %0d",
                                 got.line_length_now, want.line_length_now));
        endtask
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    tcs_pkg::tcs_in_t  s_item;
    logic              m_valid;
    logic              m_ready;
    tcs_pkg::tcs_out_t m_item;

    stats_board sb;
    int         burst_left;
    int         items_sent;
    bit         hold_due;

    text_character_statistics DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // offer one item, pausing between bursts, and hold it until taken
    task automatic send_item(input tcs_pkg::tcs_func_t f, input logic [7:0] b,
                             input logic [6:0] idx);
        tcs_pkg::tcs_in_t it;
        int gap;
        it.func       = f;
        it.data_byte  = b;
        it.read_index = idx;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 250)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.take_item(it);
        items_sent++;
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: b = sb.glyphs[$urandom_range(0, 88)];
            4, 5, 6:    b = 8'h61 + 8'($urandom_range(0, 25));
            7:          b = 8'($urandom_range(0, 255));
            8:          b = ($urandom_range(0, 1) != 0) ? 8'h30 + 8'($urandom_range(0, 9))
                                                        : 8'h41 + 8'($urandom_range(0, 25));
            default: begin
                case ($urandom_range(0, 3))
                    0:       b = 8'h00;
                    1:       b = 8'h0A;
                    2:       b = 8'h80 + 8'($urandom_range(0, 127));
                    default: b = 8'hFF;
                endcase
            end
        endcase
        return b;
    endfunction

    function automatic logic [6:0] pick_index();
        if ($urandom_range(0, 15) == 0) return 7'd127;
        return 7'($urandom_range(0, 126));
    endfunction

    task automatic send_line(input int len);
        for (int k = 0; k < len; k++)
            send_item(tcs_pkg::FUNC_DATA, pick_byte(), 7'($urandom_range(0, 127)));
        send_item(tcs_pkg::FUNC_EOL, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    endtask

    initial begin
        int pick;
        int len;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_item  <= '0;
        sb = new();
        burst_left = 0;
        items_sent = 0;
        hold_due   = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // fresh counters, the two ends of the index range, one past the end
        send_item(tcs_pkg::FUNC_READ, 8'h00, 7'd0);
        send_item(tcs_pkg::FUNC_READ, 8'hFF, 7'd126);
        send_item(tcs_pkg::FUNC_READ, 8'h00, 7'd127);
        // empty line lands in bin zero
        send_item(tcs_pkg::FUNC_EOL, 8'hFF, 7'd127);
        // each class, table ends, newline and nul as plain bytes, high bytes
        send_item(tcs_pkg::FUNC_DATA, 8'h61, 7'd0);
        send_item(tcs_pkg::FUNC_DATA, 8'h7A, 7'd127);
        send_item(tcs_pkg::FUNC_DATA, 8'h41, 7'd0);
        send_item(tcs_pkg::FUNC_DATA, 8'h5A, 7'd0);
        send_item(tcs_pkg::FUNC_DATA, 8'h30, 7'd0);
        send_item(tcs_pkg::FUNC_DATA, 8'h39, 7'd0);
        send_item(tcs_pkg::FUNC_DATA, 8'h21, 7'd0);
        send_item(tcs_pkg::FUNC_DATA, 8'h20, 7'd0);
        send_item(tcs_pkg::FUNC_DATA, 8'h60, 7'd0);
        send_item(tcs_pkg::FUNC_DATA, 8'h00, 7'd0);
        send_item(tcs_pkg::FUNC_DATA, 8'h0A, 7'd0);
        send_item(tcs_pkg::FUNC_DATA, 8'h80, 7'd0);
        send_item(tcs_pkg::FUNC_DATA, 8'hFF, 7'd0);
        send_item(tcs_pkg::FUNC_DATA, 8'h2C, 7'd0);
        send_item(tcs_pkg::FUNC_EOL, 8'h00, 7'd0);
        for (int i = 31; i <= 35; i++) send_item(tcs_pkg::FUNC_READ, 8'h00, 7'(i));
        send_item(tcs_pkg::FUNC_READ, 8'h00, 7'd125);
        // a line past the cap saturates and goes to the last bin
        send_line(33);
        send_item(tcs_pkg::FUNC_READ, 8'h00, 7'd30);
        send_item(tcs_pkg::FUNC_CLEAR, 8'h00, 7'd127);
        send_item(tcs_pkg::FUNC_READ, 8'h00, 7'd126);

        hold_due = 1'b1;
        while (items_sent < ITEM_COUNT) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(0, 12);
                    6, 7, 8:          len = $urandom_range(13, 29);
                    default:          len = $urandom_range(30, 45);
                endcase
                send_line(len);
            end else if (pick < 88) begin
                send_item(tcs_pkg::FUNC_READ, 8'($urandom_range(0, 255)), pick_index());
            end else if (pick < 99) begin
                send_item(tcs_pkg::tcs_func_t'($urandom_range(0, 2)),
                          8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
            end else begin
                send_item(tcs_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)),
                          7'($urandom_range(0, 127)));
            end
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // result side: check on handshake, then choose the next ready
    initial begin
        rx_mode_t mode;
        int mode_left;
        int hold_left;
        int phase;
        m_ready <= 1'b0;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_valid && m_ready) sb.check_readout(m_item);
            if (hold_due) begin
                hold_due  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(40, 200);
                end
                mode_left--;
                phase++;
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                    default:   m_ready <= ((phase % 7) < 3);
                endcase
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

endmodule
